### design/gsp_pkg.sv
// ---------------------------------------------------------------------------
// gsp_pkg
// Types, codes and fixed widths shared by the glyph shelf packer files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

   localparam int DIM_W   = 12;  // glyph width / height
   localparam int PAD_W   = 8;   // padding and gap registers
   localparam int SIDE_W  = 14;  // atlas side, holds twice the largest maximum
   localparam int COORD_W = 15;  // pen position and the sums built on it
   localparam int OUT_W   = 13;  // reported atlas side
   localparam int ROW_W   = 6;   // reported row index
   localparam int CSR_W   = 2;   // configuration register index

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOFIT    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [CSR_W-1:0] CSR_EDGE_PADDING = 2'd0;
   localparam logic [CSR_W-1:0] CSR_COLUMN_GAP   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ROW_GAP      = 2'd2;

   localparam logic [PAD_W-1:0] GAP_RESET = 8'd2;
   localparam logic [OUT_W-1:0] SIDE_CAP  = 13'h1FFF;

   typedef struct packed {
      logic [DIM_W-1:0] glyph_width;
      logic [DIM_W-1:0] glyph_height;
      logic             last_glyph;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OUT_W-1:0] atlas_width;
      logic [OUT_W-1:0] atlas_height;
      logic [ROW_W-1:0] row_index;
      logic [DIM_W-1:0] row_height;
      logic             last_row;
   } rsp_type;

   // one glyph step of a shelf pass
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIM_W-1:0]   line;
      logic [SIDE_W-1:0]  atlas_w;
      logic [SIDE_W-1:0]  atlas_h;
      logic [DIM_W-1:0]   gw;
      logic [DIM_W-1:0]   gh;
      logic [PAD_W-1:0]   pad;
      logic [PAD_W-1:0]   cgap;
      logic [PAD_W-1:0]   rgap;
   } step_in_type;

   typedef struct packed {
      logic               wrap;
      logic               fail;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIM_W-1:0]   line;
   } step_out_type;

   function automatic logic [OUT_W-1:0] cap_side(input logic [SIDE_W-1:0] s);
      logic [OUT_W-1:0] r;
      if (s > SIDE_W'(SIDE_CAP)) begin
         r = SIDE_CAP;
      end else begin
         r = s[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/gsp_req_if.sv
// ---------------------------------------------------------------------------
// gsp_req_if
// Glyph input channel: valid, ready and one glyph word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsp_req_if;
   logic             valid;
   logic             ready;
   gsp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/gsp_rsp_if.sv
// ---------------------------------------------------------------------------
// gsp_rsp_if
// Result channel: valid, ready and one row result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsp_rsp_if;
   logic             valid;
   logic             ready;
   gsp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/gsp_shelf_step.sv
// ---------------------------------------------------------------------------
// gsp_shelf_step
// Places one glyph on the current shelf: wrap test, shelf height, bottom
// edge test and the next pen position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsp_shelf_step (
   input  var gsp_pkg::step_in_type  si,
   output var gsp_pkg::step_out_type so
);

   localparam int CW = gsp_pkg::COORD_W;

   logic [CW-1:0] right_edge;
   logic [CW-1:0] x_base;
   logic [CW-1:0] y_base;
   logic [gsp_pkg::DIM_W-1:0] line_base;
   logic [gsp_pkg::DIM_W-1:0] line_new;
   logic [CW-1:0] bottom;

   always_comb begin
      right_edge = si.x + CW'(si.gw) + CW'(si.pad);
      so.wrap    = right_edge > CW'(si.atlas_w);
      if (so.wrap) begin
         x_base    = CW'(si.pad);
         y_base    = si.y + CW'(si.line) + CW'(si.rgap);
         line_base = '0;
      end else begin
         x_base    = si.x;
         y_base    = si.y;
         line_base = si.line;
      end
      line_new = (si.gh > line_base) ? si.gh : line_base;
      bottom   = y_base + CW'(line_new);
      so.fail  = bottom > CW'(si.atlas_h);
      so.x     = x_base + CW'(si.gw) + CW'(si.cgap);
      so.y     = y_base;
      so.line  = line_new;
   end

endmodule

`default_nettype wire

### design/glyph_shelf_packer.sv
// Loading: one glyph word per cycle, ready stays high until the last glyph.
// Packing: per tried atlas size a setup state (S_CHECK), then a pass step per glyph up to
// and including the glyph whose shelf crosses the bottom edge; the winning pass adds S_FIN.
// Output: each row is read from the row store, then loaded once the output is free.
// Reset clears control, fill count and padding/gaps (2); glyph and row stores
// are not cleared, only entries written for the current set are read.
// ---------------------------------------------------------------------------
// glyph_shelf_packer
// Shelf packer for a power-of-two glyph atlas: stores a glyph set, then
// grows the atlas until every shelf fits and reports each shelf height.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glyph_shelf_packer #(
   parameter int MAX_GLYPHS = 256,
   parameter int MAX_ROWS   = 64,
   parameter int START_SIDE = 64,
   parameter int MAX_SIDE   = 2048
) (
   input  wire                              clock,
   input  wire                              reset,
   gsp_req_if.sink                          req_ch,
   gsp_rsp_if.source                        rsp_ch,
   input  wire                              csr_we,
   input  wire [gsp_pkg::CSR_W-1:0]         csr_index,
   input  wire [gsp_pkg::PAD_W-1:0]         csr_wdata
);

   localparam int IW  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int CNW = $clog2(MAX_GLYPHS + 1);
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int NB  = $clog2(MAX_GLYPHS + 2);
   localparam int NW  = (NB > RW + 1) ? NB : RW + 1;
   localparam int SW  = gsp_pkg::SIDE_W;
   localparam int DW  = gsp_pkg::DIM_W;

   localparam logic [2:0] S_LOAD    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_PASS    = 3'd2;
   localparam logic [2:0] S_FIN     = 3'd3;
   localparam logic [2:0] S_EMIT_RD = 3'd4;
   localparam logic [2:0] S_EMIT_WR = 3'd5;
   localparam logic [2:0] S_SINGLE  = 3'd6;

   // stores
   logic [2*DW-1:0] gmem [MAX_GLYPHS];
   logic [DW-1:0]   rmem [MAX_ROWS];

   // control registers
   logic [2:0]     state_ff, state_in;
   logic [CNW-1:0] count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [gsp_pkg::PAD_W-1:0] pad_ff, pad_in;
   logic [gsp_pkg::PAD_W-1:0] cgap_ff, cgap_in;
   logic [gsp_pkg::PAD_W-1:0] rgap_ff, rgap_in;

   // working registers
   logic [SW-1:0]  w_ff, w_in;
   logic [SW-1:0]  h_ff, h_in;
   logic [gsp_pkg::COORD_W-1:0] x_ff, x_in;
   logic [gsp_pkg::COORD_W-1:0] y_ff, y_in;
   logic [DW-1:0]  line_ff, line_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [CNW-1:0] i_ff, i_in;
   logic [NW-1:0]  rows_ff, rows_in;
   logic [RW-1:0]  r_ff, r_in;
   logic [1:0]     status_ff, status_in;
   gsp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [2*DW-1:0] gdata_ff;
   logic [DW-1:0]   rdata_ff;

   // memory ports
   logic          gmem_we;
   logic [IW-1:0] grd_addr;
   logic          rmem_we;

   logic req_fire;
   logic out_free;
   logic load_out;
   logic out_last;
   logic pass_last;
   logic row_last;
   logic [CNW-1:0] i_next;

   gsp_pkg::step_in_type  step_i;
   gsp_pkg::step_out_type step_o;

   gsp_shelf_step u_step (
      .si (step_i),
      .so (step_o)
   );

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign i_next    = i_ff + CNW'(1);
   assign pass_last = (i_next == count_ff);
   assign row_last  = ((NW'(r_ff) + NW'(1)) == rows_ff);
   assign gmem_we   = req_fire & (count_ff < CNW'(MAX_GLYPHS));
   assign grd_addr  = (state_ff == S_PASS) ? i_next[IW-1:0] : '0;

   always_comb begin
      step_i.x       = x_ff;
      step_i.y       = y_ff;
      step_i.line    = line_ff;
      step_i.atlas_w = w_ff;
      step_i.atlas_h = h_ff;
      step_i.gw      = gdata_ff[2*DW-1:DW];
      step_i.gh      = gdata_ff[DW-1:0];
      step_i.pad     = pad_ff;
      step_i.cgap    = cgap_ff;
      step_i.rgap    = rgap_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      line_in      = line_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      rows_in      = rows_ff;
      r_in         = r_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      load_out     = 1'b0;
      out_last     = 1'b0;
      rmem_we      = 1'b0;

      pad_in  = pad_ff;
      cgap_in = cgap_ff;
      rgap_in = rgap_ff;
      if (csr_we) begin
         case (csr_index)
            gsp_pkg::CSR_EDGE_PADDING: pad_in  = csr_wdata;
            gsp_pkg::CSR_COLUMN_GAP:   cgap_in = csr_wdata;
            gsp_pkg::CSR_ROW_GAP:      rgap_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (gmem_we) begin
                  count_in = count_ff + CNW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.data.last_glyph) begin
                  w_in = SW'(START_SIDE);
                  h_in = SW'(START_SIDE);
                  if (!gmem_we || ovf_ff) begin
                     status_in = gsp_pkg::STATUS_OVERFLOW;
                     state_in  = S_SINGLE;
                  end else begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            if (w_ff > SW'(MAX_SIDE) || h_ff > SW'(MAX_SIDE)) begin
               status_in = gsp_pkg::STATUS_NOFIT;
               state_in  = S_SINGLE;
            end else begin
               x_in     = gsp_pkg::COORD_W'(pad_ff);
               y_in     = gsp_pkg::COORD_W'(pad_ff);
               line_in  = '0;
               n_in     = '0;
               i_in     = '0;
               state_in = S_PASS;
            end
         end
         S_PASS: begin
            // close the shelf that the glyph wraps out of
            if (step_o.wrap) begin
               n_in    = n_ff + NW'(1);
               rmem_we = (n_ff < NW'(MAX_ROWS));
            end
            if (step_o.fail) begin
               if (w_ff == h_ff) begin
                  w_in = w_ff << 1;
               end else begin
                  h_in = h_ff << 1;
               end
               state_in = S_CHECK;
            end else begin
               x_in    = step_o.x;
               y_in    = step_o.y;
               line_in = step_o.line;
               i_in    = i_next;
               if (pass_last) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            rmem_we = (n_ff < NW'(MAX_ROWS));
            rows_in = n_ff + NW'(1);
            r_in    = '0;
            if (n_ff >= NW'(MAX_ROWS)) begin
               status_in = gsp_pkg::STATUS_OVERFLOW;
               state_in  = S_SINGLE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               load_out                 = 1'b1;
               out_last                 = row_last;
               rsp_data_in.status       = gsp_pkg::STATUS_OK;
               rsp_data_in.atlas_width  = gsp_pkg::cap_side(w_ff);
               rsp_data_in.atlas_height = gsp_pkg::cap_side(h_ff);
               rsp_data_in.row_index    = gsp_pkg::ROW_W'(r_ff);
               rsp_data_in.row_height   = rdata_ff;
               rsp_data_in.last_row     = row_last;
               if (row_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  r_in     = r_ff + RW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               load_out                 = 1'b1;
               out_last                 = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.atlas_width  = gsp_pkg::cap_side(w_ff);
               rsp_data_in.atlas_height = gsp_pkg::cap_side(h_ff);
               rsp_data_in.row_index    = '0;
               rsp_data_in.row_height   = '0;
               rsp_data_in.last_row     = 1'b1;
               count_in                 = '0;
               ovf_in                   = 1'b0;
               state_in                 = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pad_ff       <= gsp_pkg::GAP_RESET;
         cgap_ff      <= gsp_pkg::GAP_RESET;
         rgap_ff      <= gsp_pkg::GAP_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         pad_ff       <= pad_in;
         cgap_ff      <= cgap_in;
         rgap_ff      <= rgap_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      line_ff     <= line_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      rows_ff     <= rows_in;
      r_ff        <= r_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // glyph store, read one glyph ahead of the step
   always_ff @(posedge clock) begin
      if (gmem_we) begin
         gmem[count_ff[IW-1:0]] <= {req_ch.data.glyph_width, req_ch.data.glyph_height};
      end
      gdata_ff <= gmem[grd_addr];
   end

   // shelf height store
   always_ff @(posedge clock) begin
      if (rmem_we) begin
         rmem[n_ff[RW-1:0]] <= line_ff;
      end
      rdata_ff <= rmem[r_ff];
   end

   a_pass_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS |-> i_ff < count_ff)
      else $error("pass index beyond glyph count");

   a_pass_size: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS |-> (w_ff <= SW'(MAX_SIDE) && h_ff <= SW'(MAX_SIDE)))
      else $error("pass running at a size above the maximum");

   a_emit_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_RD || state_ff == S_EMIT_WR) |-> NW'(r_ff) < rows_ff)
      else $error("row emit index beyond row count");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      load_out && out_last |=> state_ff == S_LOAD && count_ff == '0 && !ovf_ff)
      else $error("run did not return to loading with an empty set");

endmodule

`default_nettype wire

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the glyph shelf packer. Glyph sets are streamed in with
// random idle and stall patterns; a shelf-packing predictor built from the
// stored set computes the expected row words, which are checked in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_GLYPHS = 256;
   localparam int MAX_ROWS   = 64;
   localparam int START_SIDE = 64;
   localparam int MAX_SIDE   = 2048;

   localparam int DW  = gsp_pkg::DIM_W;
   localparam int PW  = gsp_pkg::PAD_W;
   localparam int OW  = gsp_pkg::OUT_W;
   localparam int RIW = gsp_pkg::ROW_W;
   localparam int CIW = gsp_pkg::CSR_W;

   logic           clock = 1'b0;
   logic           reset;
   logic           csr_we;
   logic [CIW-1:0] csr_index;
   logic [PW-1:0]  csr_wdata;

   gsp_req_if req_ch ();
   gsp_rsp_if rsp_ch ();

   glyph_shelf_packer #(
      .MAX_GLYPHS(MAX_GLYPHS),
      .MAX_ROWS  (MAX_ROWS),
      .START_SIDE(START_SIDE),
      .MAX_SIDE  (MAX_SIDE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch.sink),
      .rsp_ch   (rsp_ch.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   int unsigned glyph_w_mem [MAX_GLYPHS];
   int unsigned glyph_h_mem [MAX_GLYPHS];
   int unsigned shelf_heights [MAX_ROWS];
   int          glyph_fill;
   bit          store_overflow;
   int unsigned pad_reg;
   int unsigned cgap_reg;
   int unsigned rgap_reg;

   gsp_pkg::rsp_type row_results_q [$];
   int      fail_count;
   int      mismatch_count;
   int      send_idle_pct;
   int      stall_pct;

   function automatic gsp_pkg::rsp_type make_row(input logic [1:0] st,
                                                 input int unsigned aw,
                                                 input int unsigned ah,
                                                 input int unsigned idx,
                                                 input int unsigned rh, input bit last);
      gsp_pkg::rsp_type r;
      r.status       = st;
      r.atlas_width  = (aw > gsp_pkg::SIDE_CAP) ? gsp_pkg::SIDE_CAP : aw[OW-1:0];
      r.atlas_height = (ah > gsp_pkg::SIDE_CAP) ? gsp_pkg::SIDE_CAP : ah[OW-1:0];
      r.row_index    = idx[RIW-1:0];
      r.row_height   = rh[DW-1:0];
      r.last_row     = last;
      return r;
   endfunction

   // one shelf pass at a fixed atlas size, rows is 0 when a shelf crosses the bottom
   function automatic bit shelf_pass(input int unsigned aw, input int unsigned ah,
                                     output int unsigned rows);
      int unsigned x, y, line, n, gw, gh;
      int          i;
      x    = pad_reg;
      y    = pad_reg;
      line = 0;
      n    = 0;
      rows = 0;
      for (i = 0; i < glyph_fill; i++) begin
         gw = glyph_w_mem[i];
         gh = glyph_h_mem[i];
         if (x + gw + pad_reg > aw) begin
            x = pad_reg;
            y = y + line + rgap_reg;
            if (n < MAX_ROWS) shelf_heights[n] = line;
            n++;
            line = 0;
         end
         if (gh > line) line = gh;
         if (y + line > ah) return 1'b0;
         x = x + gw + cgap_reg;
      end
      if (n < MAX_ROWS) shelf_heights[n] = line;
      rows = n + 1;
      return 1'b1;
   endfunction

   task automatic absorb_glyph(input gsp_pkg::req_type g);
      int unsigned aw, ah, rows, r;
      aw = START_SIDE;
      ah = START_SIDE;
      rows = 0;
      if (glyph_fill < MAX_GLYPHS) begin
         glyph_w_mem[glyph_fill] = 32'(g.glyph_width);
         glyph_h_mem[glyph_fill] = 32'(g.glyph_height);
         glyph_fill++;
      end else begin
         store_overflow = 1'b1;
      end
      if (!g.last_glyph) return;
      if (store_overflow) begin
         row_results_q.push_back(make_row(gsp_pkg::STATUS_OVERFLOW, aw, ah, 0, 0, 1'b1));
         glyph_fill     = 0;
         store_overflow = 1'b0;
         return;
      end
      forever begin
         if (aw > MAX_SIDE || ah > MAX_SIDE) begin
            row_results_q.push_back(make_row(gsp_pkg::STATUS_NOFIT, aw, ah, 0, 0, 1'b1));
            glyph_fill = 0;
            return;
         end
         if (shelf_pass(aw, ah, rows)) break;
         if (aw == ah) aw = aw * 2;
         else ah = ah * 2;
      end
      glyph_fill = 0;
      if (rows > MAX_ROWS) begin
         row_results_q.push_back(make_row(gsp_pkg::STATUS_OVERFLOW, aw, ah, 0, 0, 1'b1));
         return;
      end
      for (r = 0; r < rows; r++) begin
         row_results_q.push_back(make_row(gsp_pkg::STATUS_OK, aw, ah, r, shelf_heights[r],
                                          r + 1 == rows));
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_glyph(input int unsigned gw, input int unsigned gh, input bit last);
      gsp_pkg::req_type g;
      g.glyph_width  = gw[DW-1:0];
      g.glyph_height = gh[DW-1:0];
      g.last_glyph   = last;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= g;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_glyph(g);
      @(negedge clock);
   endtask

   // wait for every row word, then let the block fall idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (row_results_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_spacing(input logic [PW-1:0] pad, input logic [PW-1:0] cgap,
                                  input logic [PW-1:0] rgap);
      logic [CIW-1:0] idx [3];
      logic [PW-1:0]  val [3];
      int             k;
      idx = '{gsp_pkg::CSR_EDGE_PADDING, gsp_pkg::CSR_COLUMN_GAP, gsp_pkg::CSR_ROW_GAP};
      val = '{pad, cgap, rgap};
      for (k = 0; k < 3; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         case (idx[k])
            gsp_pkg::CSR_EDGE_PADDING: pad_reg  = 32'(val[k]);
            gsp_pkg::CSR_COLUMN_GAP:   cgap_reg = 32'(val[k]);
            gsp_pkg::CSR_ROW_GAP:      rgap_reg = 32'(val[k]);
            default: ;
         endcase
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic int unsigned pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(0, 40);
      if (r < 90) return $urandom_range(0, 400);
      return $urandom_range(0, 4095);
   endfunction

   // reset spacing, one glyph per set
   task automatic test_single_glyphs();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_glyph(0, 0, 1'b1);
      send_glyph(4095, 4095, 1'b1);   // grows past the largest side
      send_glyph(100, 10, 1'b1);      // wider than the atlas: empty first shelf
      send_glyph(60, 62, 1'b1);       // touches the bottom edge exactly
      send_glyph(60, 63, 1'b1);       // one past it
      settle();
   endtask

   task automatic test_shelf_wrap();
      send_glyph(30, 5, 1'b0);
      send_glyph(30, 9, 1'b0);
      send_glyph(30, 7, 1'b1);
      send_glyph(0, 4095, 1'b0);
      send_glyph(4095, 0, 1'b1);
      settle();
   endtask

   // width doubles on a square atlas, height otherwise
   task automatic test_atlas_growth();
      send_glyph(60, 60, 1'b0);
      send_glyph(60, 60, 1'b1);
      send_glyph(60, 60, 1'b0);
      send_glyph(60, 60, 1'b0);
      send_glyph(60, 60, 1'b1);
      settle();
      program_spacing(8'd0, 8'd0, 8'd0);
      send_glyph(64, 64, 1'b0);
      send_glyph(1, 1, 1'b1);
      settle();
      program_spacing(8'd255, 8'd255, 8'd255);
      send_glyph(1, 1, 1'b0);
      send_glyph(1, 1, 1'b1);
      settle();
      program_spacing(gsp_pkg::GAP_RESET, gsp_pkg::GAP_RESET, gsp_pkg::GAP_RESET);
   endtask

   // one glyph past the store depth, the extra one carrying the last flag
   task automatic test_store_limits();
      int i;
      send_idle_pct = 52;
      stall_pct     = 0;
      for (i = 0; i <= MAX_GLYPHS; i++) begin
         send_glyph($urandom_range(0, 40), $urandom_range(0, 40), i == MAX_GLYPHS);
      end
      send_glyph(10, 10, 1'b1);
      settle();
   endtask

   // every glyph too wide, so each one opens a shelf: n glyphs give n+1 rows
   task automatic test_row_limits();
      int i, n;
      send_idle_pct = 0;
      stall_pct     = 52;
      for (n = MAX_ROWS - 1; n <= MAX_ROWS; n++) begin
         for (i = 0; i < n; i++) begin
            send_glyph($urandom_range(2100, 4095), $urandom_range(0, 15), i == n - 1);
         end
      end
      settle();
   endtask

   task automatic test_random_sets(input int items, input int idle_pct, input int stall,
                                   input logic [PW-1:0] pad, input logic [PW-1:0] cgap,
                                   input logic [PW-1:0] rgap);
      int sent, n, i, kind;
      sent = 0;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      program_spacing(pad, cgap, rgap);
      while (sent < items) begin
         kind = $urandom_range(99);
         if (kind < 70) n = $urandom_range(1, 8);
         else if (kind < 85) n = $urandom_range(9, 40);
         else n = $urandom_range(1, 4);
         if (n > items - sent) n = items - sent;
         for (i = 0; i < n; i++) begin
            if (kind >= 85) send_glyph($urandom_range(0, 4095), $urandom_range(0, 4095),
                                       i == n - 1);
            else send_glyph(pick_dim(), pick_dim(), i == n - 1);
         end
         sent += n;
      end
      settle();
   endtask

   // result side: random back-pressure, check against the oldest expectation
   always @(negedge clock) begin
      rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      gsp_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (row_results_q.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected row word: st=%0d w=%0d h=%0d row=%0d rh=%0d last=%0d",
                        rsp_ch.data.status, rsp_ch.data.atlas_width, rsp_ch.data.atlas_height,
                        rsp_ch.data.row_index, rsp_ch.data.row_height, rsp_ch.data.last_row);
         end else begin
            want = row_results_q.pop_front();
            if (rsp_ch.data !== want) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("row word mismatch: exp st=%0d w=%0d h=%0d row=%0d rh=%0d last=%0d, %s",
                           want.status, want.atlas_width, want.atlas_height, want.row_index,
                           want.row_height, want.last_row,
                           $sformatf("got st=%0d w=%0d h=%0d row=%0d rh=%0d last=%0d",
                                     rsp_ch.data.status, rsp_ch.data.atlas_width,
                                     rsp_ch.data.atlas_height, rsp_ch.data.row_index,
                                     rsp_ch.data.row_height, rsp_ch.data.last_row));
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = gsp_pkg::CSR_EDGE_PADDING;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;
      rsp_ch.ready   = 1'b0;
      glyph_fill     = 0;
      store_overflow = 1'b0;
      pad_reg        = 32'(gsp_pkg::GAP_RESET);
      cgap_reg       = 32'(gsp_pkg::GAP_RESET);
      rgap_reg       = 32'(gsp_pkg::GAP_RESET);
      fail_count     = 0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_glyphs();
      test_shelf_wrap();
      test_atlas_growth();
      test_store_limits();
      test_row_limits();
      test_random_sets(6, 0, 0, 8'd0, 8'd0, 8'd0);
      test_random_sets(6, 52, 0, PW'($urandom_range(0, 8)), PW'($urandom_range(0, 8)),
                       PW'($urandom_range(0, 8)));
      test_random_sets(6, 0, 52, 8'd255, 8'd255, 8'd255);
      test_random_sets(6, 18, 18, PW'($urandom_range(0, 255)), PW'($urandom_range(0, 255)),
                       PW'($urandom_range(0, 255)));

      repeat (20) @(posedge clock);
      fail_count += row_results_q.size();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

### glyph_shelf_packer.f
design/gsp_pkg.sv
design/gsp_req_if.sv
design/gsp_rsp_if.sv
design/gsp_shelf_step.sv
design/glyph_shelf_packer.sv
verif/tb_top.sv
